### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BPD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bpd same-cycle check failed");

// next-cycle implication, sampled on aclk, off during reset
`define BPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bpd next-cycle check failed");

`endif

### rtl/bpd_pkg.sv
// shared types, constants and helpers of the balance pid drive controller
package bpd_pkg;

    localparam int WINDOW_DEF = 10;

    localparam logic [7:0] SETTLE_TICKS   = 8'd10;
    localparam logic [7:0] SHRINK_CHANGES = 8'd5;
    localparam logic [6:0] SHRINK_DRIVE   = 7'd20;
    localparam logic signed [31:0] SHRINK_ERR = 32'sd13108;
    localparam logic signed [31:0] SETTLE_ERR = 32'sd65536;
    localparam logic [6:0] BRAKE_LEVEL    = 7'd127;
    localparam logic signed [53:0] OUT_LIM = 54'sd127 <<< 24;

    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_HOLD = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_SETPOINT  = 3'd3;
    localparam logic [2:0] REG_STEP      = 3'd4;
    localparam logic [2:0] REG_PERIOD    = 3'd5;
    localparam logic [2:0] REG_RATE      = 3'd6;
    localparam logic [2:0] REG_BRAKE     = 3'd7;

    localparam logic [15:0] GAIN_P_RST = 16'd10240;
    localparam logic [15:0] GAIN_I_RST = 16'd0;
    localparam logic [15:0] GAIN_D_RST = 16'd77;
    localparam logic signed [23:0] SETPOINT_RST = -24'sd80609;
    localparam logic [15:0] STEP_RST   = 16'd655;
    localparam logic [15:0] PERIOD_RST = 16'd328;
    localparam logic [9:0]  RATE_RST   = 10'd200;
    localparam logic [7:0]  BRAKE_RST  = 8'd3;

    // reciprocal of 5 for the step shrink, exact for 18-bit inputs
    localparam logic [17:0] RECIP5 = 18'd209716;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_FRONT  = 4'd1;
    localparam logic [3:0] OP_AVGMUL = 4'd2;
    localparam logic [3:0] OP_AVG    = 4'd3;
    localparam logic [3:0] OP_ERR    = 4'd4;
    localparam logic [3:0] OP_INTMUL = 4'd5;
    localparam logic [3:0] OP_INT    = 4'd6;
    localparam logic [3:0] OP_DERIV  = 4'd7;
    localparam logic [3:0] OP_ACCP   = 4'd8;
    localparam logic [3:0] OP_ACCI   = 4'd9;
    localparam logic [3:0] OP_ACCD   = 4'd10;
    localparam logic [3:0] OP_OUT    = 4'd11;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
    } cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/bpd_datapath.sv
// datapath: config registers, angle window, shared multiplier, pid and drive logic
module bpd_datapath #(
    parameter int WINDOW = bpd_pkg::WINDOW_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    input  bpd_pkg::cmd_t     cmd,
    input  logic signed [15:0] tilt_angle,
    input  logic [15:0]       encoder_count,
    output logic              braking,
    output logic [1:0]        direction,
    output logic [6:0]        drive_level
);
    localparam int CW = $clog2(WINDOW);
    localparam int SW = 17 + CW;
    localparam int K  = SW;
    localparam int MREC = (2 ** K) / WINDOW;
    localparam int BIAS = WINDOW * 32768;

    // configuration
    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg, period_reg;
    logic [9:0]  rate_reg;
    logic [7:0]  brake_reg;

    // tick state
    logic signed [15:0] win_reg [WINDOW];
    logic signed [SW-1:0] sum_reg;
    logic               primed_reg;
    logic signed [15:0] sample_reg, prev_angle_reg, avg_reg, counts_reg;
    logic [15:0]        enc_reg, last_enc_reg;
    logic signed [31:0] integ_reg, target_reg, err_reg, last_err_reg;
    logic [15:0]        step_reg;
    logic               step_sign_reg, prev_sign_reg, chg_reg;
    logic [7:0]         cnt_reg, settle_reg;
    logic [1:0]         dir_cur_reg, prev_dir_reg;
    logic [6:0]         last_drive_reg;
    logic signed [27:0] deriv_reg;
    logic signed [53:0] acc_reg;
    logic signed [65:0] prod_reg;
    logic               res_brk_reg;
    logic [1:0]         res_dir_reg;
    logic [6:0]         res_drv_reg;

    // nudge
    logic               nudge_go, sign_next, shrink;
    logic signed [33:0] step_ext, tgt_sum;
    logic [7:0]         cnt_inc;
    logic [35:0]        shr_prod;

    // average
    logic [SW-1:0]      s_pos, qw, rem;
    logic [16:0]        q_est, q_fix;

    // multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [16:0] ang_dif;

    // output stage
    logic signed [53:0] pid_c, pid_mag;
    logic [6:0]         drive_new;
    logic [1:0]         dir_new;
    logic               chg_mid, brake_now, dir_diff;
    logic [7:0]         settle_mid;

    always_comb begin
        nudge_go  = !chg_reg && (settle_reg >= bpd_pkg::SETTLE_TICKS);
        sign_next = (dir_cur_reg == bpd_pkg::DIR_REV) ? 1'b0 :
                    (dir_cur_reg == bpd_pkg::DIR_FWD) ? 1'b1 : step_sign_reg;
        step_ext  = $signed({18'd0, step_reg});
        tgt_sum   = 34'(target_reg) + (sign_next ? step_ext : -step_ext);
        cnt_inc   = cnt_reg + 8'd1;
        shrink    = (cnt_inc > bpd_pkg::SHRINK_CHANGES)
                    && (last_err_reg < bpd_pkg::SHRINK_ERR)
                    && (last_drive_reg < bpd_pkg::SHRINK_DRIVE);
        shr_prod  = {step_reg, 2'b00} * bpd_pkg::RECIP5;
    end

    // floor division by the window length via a biased, nonnegative sum
    always_comb begin
        s_pos = $unsigned(sum_reg + SW'(BIAS));
        q_est = prod_reg[K+16:K];
        qw    = SW'(q_est) * SW'(WINDOW);
        rem   = s_pos - qw;
        q_fix = q_est + ((rem >= SW'(WINDOW)) ? 17'd1 : 17'd0);
    end

    always_comb begin
        ang_dif = 17'(avg_reg) - 17'(prev_angle_reg);
        mul_a   = '0;
        mul_b   = '0;
        case (cmd.op)
            bpd_pkg::OP_AVGMUL: begin
                mul_a = $signed(33'(s_pos));
                mul_b = 33'(MREC);
            end
            bpd_pkg::OP_INTMUL: begin
                mul_a = 33'(err_reg);
                mul_b = $signed({17'd0, period_reg});
            end
            bpd_pkg::OP_INT: begin
                mul_a = 33'(ang_dif);
                mul_b = $signed({23'd0, rate_reg});
            end
            bpd_pkg::OP_DERIV: begin
                mul_a = $signed({17'd0, gain_p_reg});
                mul_b = 33'(err_reg);
            end
            bpd_pkg::OP_ACCP: begin
                mul_a = $signed({17'd0, gain_i_reg});
                mul_b = 33'(integ_reg);
            end
            bpd_pkg::OP_ACCI: begin
                mul_a = $signed({17'd0, gain_d_reg});
                mul_b = 33'(deriv_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (acc_reg > bpd_pkg::OUT_LIM) begin
            pid_c = bpd_pkg::OUT_LIM;
        end else if (acc_reg < -bpd_pkg::OUT_LIM) begin
            pid_c = -bpd_pkg::OUT_LIM;
        end else begin
            pid_c = acc_reg;
        end
        pid_mag   = (pid_c < 0) ? -pid_c : pid_c;
        drive_new = pid_mag[30:24];
        dir_new   = (err_reg < 0) ? bpd_pkg::DIR_REV :
                    (err_reg > 0) ? bpd_pkg::DIR_FWD : bpd_pkg::DIR_HOLD;
        dir_diff  = (dir_new != prev_dir_reg);
        chg_mid   = dir_diff || chg_reg;
        if (dir_diff) begin
            settle_mid = '0;
        end else if (err_reg > -bpd_pkg::SETTLE_ERR && err_reg < bpd_pkg::SETTLE_ERR
                     && settle_reg != 8'hFF) begin
            settle_mid = settle_reg + 8'd1;
        end else begin
            settle_mid = settle_reg;
        end
        brake_now = chg_mid && (counts_reg > $signed({8'd0, brake_reg}));
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= tilt_angle;
            enc_reg    <= encoder_count;
        end
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            bpd_pkg::OP_FRONT: begin
                counts_reg <= $signed(enc_reg - last_enc_reg);
                if (!primed_reg) begin
                    for (int i = 0; i < WINDOW; i++) begin
                        win_reg[i] <= sample_reg;
                    end
                    sum_reg <= SW'(sample_reg) * $signed(SW'(WINDOW));
                end else begin
                    for (int i = 0; i < WINDOW - 1; i++) begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    win_reg[WINDOW-1] <= sample_reg;
                    sum_reg <= sum_reg - SW'(win_reg[0]) + SW'(sample_reg);
                end
            end
            bpd_pkg::OP_AVG:   avg_reg <= {~q_fix[15], q_fix[14:0]};
            bpd_pkg::OP_ERR:   err_reg <= bpd_pkg::sat32(66'(target_reg) - (66'(avg_reg) <<< 8));
            bpd_pkg::OP_DERIV: deriv_reg <= prod_reg[27:0];
            bpd_pkg::OP_ACCP:  acc_reg <= prod_reg[53:0];
            bpd_pkg::OP_ACCI:  acc_reg <= acc_reg + prod_reg[53:0];
            bpd_pkg::OP_ACCD:  acc_reg <= acc_reg + (prod_reg[53:0] <<< 8);
            bpd_pkg::OP_OUT: begin
                res_brk_reg <= brake_now;
                res_dir_reg <= brake_now ? bpd_pkg::DIR_HOLD : dir_new;
                res_drv_reg <= brake_now ? bpd_pkg::BRAKE_LEVEL : drive_new;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg     <= bpd_pkg::GAIN_P_RST;
            gain_i_reg     <= bpd_pkg::GAIN_I_RST;
            gain_d_reg     <= bpd_pkg::GAIN_D_RST;
            period_reg     <= bpd_pkg::PERIOD_RST;
            rate_reg       <= bpd_pkg::RATE_RST;
            brake_reg      <= bpd_pkg::BRAKE_RST;
            target_reg     <= 32'(bpd_pkg::SETPOINT_RST);
            step_reg       <= bpd_pkg::STEP_RST;
            primed_reg     <= 1'b0;
            prev_angle_reg <= '0;
            integ_reg      <= '0;
            step_sign_reg  <= 1'b1;
            prev_sign_reg  <= 1'b1;
            cnt_reg        <= '0;
            settle_reg     <= '0;
            dir_cur_reg    <= bpd_pkg::DIR_FWD;
            prev_dir_reg   <= bpd_pkg::DIR_FWD;
            chg_reg        <= 1'b0;
            last_enc_reg   <= '0;
            last_err_reg   <= '0;
            last_drive_reg <= '0;
        end else begin
            case (cmd.op)
                bpd_pkg::OP_FRONT: begin
                    primed_reg   <= 1'b1;
                    last_enc_reg <= enc_reg;
                    if (nudge_go) begin
                        step_sign_reg <= sign_next;
                        prev_sign_reg <= sign_next;
                        settle_reg    <= '0;
                        target_reg    <= bpd_pkg::sat32(66'(tgt_sum));
                        if (prev_sign_reg != sign_next) begin
                            if (shrink) begin
                                step_reg <= shr_prod[35:20];
                                cnt_reg  <= '0;
                            end else begin
                                cnt_reg <= cnt_inc;
                            end
                        end
                    end
                end
                bpd_pkg::OP_INT: begin
                    integ_reg <= bpd_pkg::sat32(66'(integ_reg) + (prod_reg >>> 16));
                end
                bpd_pkg::OP_OUT: begin
                    prev_angle_reg <= avg_reg;
                    last_err_reg   <= err_reg;
                    last_drive_reg <= drive_new;
                    dir_cur_reg    <= dir_new;
                    settle_reg     <= settle_mid;
                    if (chg_mid && !brake_now) begin
                        chg_reg      <= 1'b0;
                        prev_dir_reg <= dir_new;
                    end else begin
                        chg_reg <= chg_mid;
                    end
                end
                default: begin
                end
            endcase
            if (cfg_wr_en) begin
                case (cfg_index)
                    bpd_pkg::REG_GAIN_P: gain_p_reg <= cfg_data[15:0];
                    bpd_pkg::REG_GAIN_I: gain_i_reg <= cfg_data[15:0];
                    bpd_pkg::REG_GAIN_D: gain_d_reg <= cfg_data[15:0];
                    bpd_pkg::REG_SETPOINT: target_reg <= 32'($signed(cfg_data));
                    bpd_pkg::REG_STEP:   step_reg   <= cfg_data[15:0];
                    bpd_pkg::REG_PERIOD: period_reg <= cfg_data[15:0];
                    bpd_pkg::REG_RATE:   rate_reg   <= cfg_data[9:0];
                    bpd_pkg::REG_BRAKE:  brake_reg  <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign braking     = res_brk_reg;
    assign direction   = res_dir_reg;
    assign drive_level = res_drv_reg;

endmodule

### rtl/bpd_ctrl.sv
// controller: tick sequencer and result word handshake
module bpd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output bpd_pkg::cmd_t cmd
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FRONT  = 4'd1;
    localparam logic [3:0] ST_AVGMUL = 4'd2;
    localparam logic [3:0] ST_AVG    = 4'd3;
    localparam logic [3:0] ST_ERR    = 4'd4;
    localparam logic [3:0] ST_INTMUL = 4'd5;
    localparam logic [3:0] ST_INT    = 4'd6;
    localparam logic [3:0] ST_DERIV  = 4'd7;
    localparam logic [3:0] ST_ACCP   = 4'd8;
    localparam logic [3:0] ST_ACCI   = 4'd9;
    localparam logic [3:0] ST_ACCD   = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       fire;

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.op       = bpd_pkg::OP_NONE;
        fire         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) state_next = ST_FRONT;
            end
            ST_FRONT: begin
                cmd.op = bpd_pkg::OP_FRONT;  state_next = ST_AVGMUL;
            end
            ST_AVGMUL: begin
                cmd.op = bpd_pkg::OP_AVGMUL; state_next = ST_AVG;
            end
            ST_AVG: begin
                cmd.op = bpd_pkg::OP_AVG;    state_next = ST_ERR;
            end
            ST_ERR: begin
                cmd.op = bpd_pkg::OP_ERR;    state_next = ST_INTMUL;
            end
            ST_INTMUL: begin
                cmd.op = bpd_pkg::OP_INTMUL; state_next = ST_INT;
            end
            ST_INT: begin
                cmd.op = bpd_pkg::OP_INT;    state_next = ST_DERIV;
            end
            ST_DERIV: begin
                cmd.op = bpd_pkg::OP_DERIV;  state_next = ST_ACCP;
            end
            ST_ACCP: begin
                cmd.op = bpd_pkg::OP_ACCP;   state_next = ST_ACCI;
            end
            ST_ACCI: begin
                cmd.op = bpd_pkg::OP_ACCI;   state_next = ST_ACCD;
            end
            ST_ACCD: begin
                cmd.op = bpd_pkg::OP_ACCD;   state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait here until the output word slot is free
                if (!m_valid_reg || m_tready) begin
                    cmd.op     = bpd_pkg::OP_OUT;
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

### rtl/balance_pid_drive_controller.sv
// balance pid drive controller: one input word in, one result word out per tick
// the result word is registered in the OUT step, which waits while the previous result word is still unaccepted
// each word runs the accept step plus 11 sequenced datapath steps, FRONT through OUT, before the next is taken
// the result waits in an output register; the next word is taken while it waits
// reset: synchronous, active low; clears control state, loads register reset values
// no clearing pass after reset, the first word fills the angle window
module balance_pid_drive_controller #(
    parameter int WINDOW = bpd_pkg::WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] tilt_angle, [31:16] encoder_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] braking, [2:1] direction, [9:3] drive_level, zeros
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    bpd_pkg::cmd_t cmd;
    logic          braking;
    logic [1:0]    direction;
    logic [6:0]    drive_level;

    bpd_datapath #(.WINDOW(WINDOW)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .tilt_angle    ($signed(s_tdata[15:0])),
        .encoder_count (s_tdata[31:16]),
        .braking       (braking),
        .direction     (direction),
        .drive_level   (drive_level)
    );

    bpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    assign m_tdata = {6'd0, drive_level, direction, braking};

endmodule

### rtl/bpd_checker.sv
// port-level checker for the balance pid drive controller, bound to the top level
`include "assert_macros.svh"

module bpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    logic [1:0] m_dir;
    logic [6:0] m_lvl;
    logic       brk_word_ok;

    assign m_dir       = m_tdata[2:1];
    assign m_lvl       = m_tdata[9:3];
    assign brk_word_ok = (m_dir == bpd_pkg::DIR_HOLD) && (m_lvl == bpd_pkg::BRAKE_LEVEL);

    `BPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BPD_ASSERT_SAME(a_brake_word, m_tvalid && m_tdata[0], brk_word_ok)
    `BPD_ASSERT_SAME(a_dir_code, m_tvalid, m_dir != 2'd3 && m_tdata[15:10] == 6'd0)
    `BPD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind balance_pid_drive_controller bpd_checker u_bpd_checker (.*);

### tb/balance_pid_drive_controller_test.sv
// testbench of the balance pid drive controller: predicted drive results checked word by word
module balance_pid_drive_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = 10;

    typedef struct packed {
        logic       braking;
        logic [1:0] direction;
        logic [6:0] drive_level;
    } drive_t;

    // predictor of the controller and queue of predicted drive words
    class drive_board;
        logic [15:0] kp, ki, kd, step0, period;
        logic [9:0] rate;
        logic [7:0] brake_thr;
        logic signed [31:0] setpoint0;
        logic signed [15:0] win [WIN];
        bit primed;
        logic signed [15:0] prev_avg;
        logic signed [31:0] integ, target, last_err;
        logic [15:0] tstep, last_enc;
        bit ssign, psign, changing;
        logic [7:0] changes, settled;
        logic [1:0] cur_dir, prev_dir;
        logic [6:0] last_drv;
        drive_t pending[$];
        int errors;

        function new();
            kp = bpd_pkg::GAIN_P_RST; ki = bpd_pkg::GAIN_I_RST; kd = bpd_pkg::GAIN_D_RST;
            setpoint0 = 32'(bpd_pkg::SETPOINT_RST); step0 = bpd_pkg::STEP_RST;
            period = bpd_pkg::PERIOD_RST;
            rate = bpd_pkg::RATE_RST; brake_thr = bpd_pkg::BRAKE_RST;
            primed = 0; prev_avg = 0; integ = 0; target = setpoint0; tstep = step0;
            ssign = 1; psign = 1; changes = 0; settled = 0; cur_dir = bpd_pkg::DIR_FWD;
            prev_dir = bpd_pkg::DIR_FWD; changing = 0; last_enc = 0; last_err = 0;
            last_drv = 0;
            errors = 0;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] d);
            case (idx)
                bpd_pkg::REG_GAIN_P: kp = d[15:0];
                bpd_pkg::REG_GAIN_I: ki = d[15:0];
                bpd_pkg::REG_GAIN_D: kd = d[15:0];
                bpd_pkg::REG_SETPOINT: begin
                    setpoint0 = {{8{d[23]}}, d};
                    target = setpoint0;
                end
                bpd_pkg::REG_STEP: begin
                    step0 = d[15:0];
                    tstep = step0;
                end
                bpd_pkg::REG_PERIOD: period = d[15:0];
                bpd_pkg::REG_RATE: rate = d[9:0];
                bpd_pkg::REG_BRAKE: brake_thr = d[7:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [15:0] ang, logic [15:0] enc);
            longint sum, avg, err, prod, deriv, pid, lim;
            logic [15:0] diff;
            longint counts;
            drive_t r;
            logic [6:0] drv;
            if (!changing && settled >= bpd_pkg::SETTLE_TICKS) begin
                if (cur_dir == bpd_pkg::DIR_REV) ssign = 0;
                else if (cur_dir == bpd_pkg::DIR_FWD) ssign = 1;
                settled = 0;
                target = 32'(clip32(longint'(target) +
                    (ssign ? longint'(tstep) : -longint'(tstep))));
                if (psign != ssign) begin
                    changes = changes + 8'd1;
                    if (changes > bpd_pkg::SHRINK_CHANGES && longint'(last_err) * 5 < 65536
                        && last_drv < bpd_pkg::SHRINK_DRIVE) begin
                        tstep = 16'((32'(tstep) * 4) / 5);
                        changes = 0;
                    end
                end
                psign = ssign;
            end
            if (!primed) begin
                foreach (win[i]) win[i] = ang;
                primed = 1;
            end else begin
                for (int i = 0; i < WIN - 1; i++) win[i] = win[i + 1];
                win[WIN - 1] = ang;
            end
            sum = 0;
            foreach (win[i]) sum += win[i];
            avg = sum >= 0 ? sum / WIN : -((-sum + WIN - 1) / WIN);
            diff = enc - last_enc;
            counts = longint'($signed(diff));
            last_enc = enc;
            err = clip32(longint'(target) - avg * 256);
            prod = err * longint'(period);
            prod = prod >= 0 ? prod >>> 16 : -((-prod + 65535) >>> 16);
            integ = 32'(clip32(longint'(integ) + prod));
            deriv = (avg - longint'(prev_avg)) * longint'(rate);
            pid = longint'(kp) * err + longint'(ki) * longint'(integ)
                + longint'(kd) * deriv * 256;
            prev_avg = 16'(avg);
            lim = 64'sd127 <<< 24;
            if (pid > lim) pid = lim;
            if (pid < -lim) pid = -lim;
            drv = 7'((pid < 0 ? -pid : pid) >>> 24);
            cur_dir = err < 0 ? bpd_pkg::DIR_REV : (err > 0 ? bpd_pkg::DIR_FWD : bpd_pkg::DIR_HOLD);
            last_err = 32'(err);
            last_drv = drv;
            if (cur_dir != prev_dir) begin
                changing = 1;
                settled = 0;
            end else if (err > -65536 && err < 65536) begin
                if (settled < 255) settled++;
            end
            r = '{1'b0, cur_dir, drv};
            if (changing) begin
                if (counts > longint'(brake_thr))
                    r = '{1'b1, bpd_pkg::DIR_HOLD, bpd_pkg::BRAKE_LEVEL};
                else begin
                    changing = 0;
                    prev_dir = cur_dir;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] word);
            drive_t got, want;
            got.braking     = word[0];
            got.direction   = word[2:1];
            got.drive_level = word[9:3];
            if (pending.size() == 0 || word[15:10] != 0) begin
                errors++;
                if (errors <= 10) $display("unexpected or malformed result %h", word);
                if (pending.size() != 0) void'(pending.pop_front());
                return;
            end
            want = pending.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected brk %b dir %0d lvl %0d, %s %b dir %0d lvl %0d",
                        want.braking, want.direction, want.drive_level, "got brk",
                        got.braking, got.direction, got.drive_level);
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, cfg_wr_en = 0;
    logic [31:0] s_tdata = 0;
    logic [15:0] m_tdata;
    logic [2:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;
    drive_board board;
    int idle_cycles = 0;
    bit hold_off = 0;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    balance_pid_drive_controller DUT (.*);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 4000) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls per word, plus a long hold-off when asked
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (300) @(negedge aclk);
                hold_off = 0;
            end
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (w > 0) begin
                m_tready <= 0;
                repeat (w - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // valid stays high after the accepting edge until the next word or a gap
    task automatic send_word(logic signed [15:0] ang, logic [15:0] enc, bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 17);
        repeat (w) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {enc, ang};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(ang, enc);
        @(negedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] d);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        board.write_reg(idx, d);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic random_regs(int mode);
        cfg_write(bpd_pkg::REG_GAIN_P,
            mode == 0 ? 24'd0 : (mode == 1 ? 24'hFFFF : 24'($urandom_range(0, 65535))));
        cfg_write(bpd_pkg::REG_GAIN_I,
            mode == 0 ? 24'd0 : (mode == 1 ? 24'hFFFF : 24'($urandom_range(0, 600))));
        cfg_write(bpd_pkg::REG_GAIN_D,
            mode == 0 ? 24'd0 : (mode == 1 ? 24'hFFFF : 24'($urandom_range(0, 400))));
        cfg_write(bpd_pkg::REG_SETPOINT, mode == 0 ? 24'(-5898240) :
            (mode == 1 ? 24'd5898240 : 24'($signed($urandom_range(0, 400000)) - 200000)));
        cfg_write(bpd_pkg::REG_STEP,
            mode == 0 ? 24'd0 : (mode == 1 ? 24'hFFFF : 24'($urandom_range(0, 5000))));
        cfg_write(bpd_pkg::REG_PERIOD,
            mode == 0 ? 24'd1 : (mode == 1 ? 24'hFFFF : 24'($urandom_range(1, 65535))));
        cfg_write(bpd_pkg::REG_RATE,
            mode == 0 ? 24'd1 : (mode == 1 ? 24'd1000 : 24'($urandom_range(1, 1000))));
        cfg_write(bpd_pkg::REG_BRAKE,
            mode == 0 ? 24'd0 : (mode == 1 ? 24'd255 : 24'($urandom_range(0, 255))));
    endtask

    initial begin
        logic signed [15:0] ang;
        logic [15:0] enc;
        board = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: field extremes, forward and reverse wheel motion
        send_word(16'sd23040, 16'd0, 0);
        send_word(-16'sd23040, 16'd100, 0);
        send_word(-16'sd23040, 16'd50, 0);
        send_word(16'sd0, 16'hFFFF, 0);
        send_word(16'sd23040, 16'h8000, 0);
        send_word(16'sh8000, 16'h7FFF, 0);
        send_word(16'sh7FFF, 16'h7FFF, 0);
        send_word(16'shFFFF, 16'h7FFF, 0);
        for (int i = 0; i < 14; i++) send_word(-16'sd79, 16'h7FFF, 0);
        drain();
        for (int phase = 0; phase < 6; phase++) begin
            random_regs(phase < 2 ? phase : 2);
            if (phase == 3) cfg_write(3'(bpd_pkg::REG_BRAKE), 24'd5);
            cfg_wr_en <= 0;
            ang = 16'($urandom_range(0, 4000));
            enc = 16'($urandom);
            for (int i = 0; i < 200; i++) begin
                if (phase == 2 && i == 20) hold_off = 1;
                // mostly small angles near balance so the settle and nudge paths run
                case ($urandom_range(0, 9))
                    0: ang = 16'($urandom);
                    1: ang = 16'($signed($urandom_range(0, 46080)) - 23040);
                    default: ang = 16'($signed($urandom_range(0, 600)) - 300);
                endcase
                enc = enc + 16'($signed($urandom_range(0, 20)) - 10);
                if ($urandom_range(0, 30) == 0) enc = 16'($urandom);
                send_word(ang, enc, phase == 2 && i >= 20 && i < 60);
            end
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
